// ===== hw/rtl/clw_pkg.sv =====
package clw_pkg;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned StepW      = 5;

    typedef enum logic [2:0] {
        ActInit   = 3'd0,
        ActData   = 3'd1,
        ActCmd    = 3'd2,
        ActCursor = 3'd3,
        ActClear  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        CfgPowerUpWait = 2'd0,
        CfgPulse       = 2'd1,
        CfgClearWait   = 2'd2
    } cfg_index_t;

    localparam logic [7:0] LineOneBase = 8'h40;
    localparam logic [7:0] CmdSetDdram = 8'h80;
    localparam logic [3:0] WakeNibble  = 4'h3;
    localparam logic [3:0] FourBitNib  = 4'h2;
    localparam logic [7:0] CmdFunction = 8'h28;
    localparam logic [7:0] CmdDispOff  = 8'h08;
    localparam logic [7:0] CmdClear    = 8'h01;
    localparam logic [7:0] CmdEntry    = 8'h06;
    localparam logic [7:0] CmdDispOn   = 8'h0C;

    localparam logic [7:0] WakeExtraA  = 8'd5;
    localparam logic [7:0] WakeExtraB  = 8'd1;

    // step codes for the init sequence
    localparam logic [StepW-1:0] InitWaitStep  = 5'd0;
    localparam logic [StepW-1:0] InitNibLast   = 5'd8;
    localparam logic [StepW-1:0] InitCmdFirst  = 5'd9;
    localparam logic [StepW-1:0] InitLastStep  = 5'd28;

    typedef struct packed {
        logic [7:0] power_up_wait_ms;
        logic [7:0] pulse_ms;
        logic [7:0] clear_wait_ms;
    } clw_cfg_t;

    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] byte_val;
        logic [7:0] extra_ms;
    } clw_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } clw_q_status_t;

    function automatic logic [7:0] init_cmd(input logic [2:0] j);
        logic [7:0] c;
        case (j)
            3'd0:    c = CmdFunction;
            3'd1:    c = CmdDispOff;
            3'd2:    c = CmdClear;
            3'd3:    c = CmdEntry;
            3'd4:    c = CmdDispOn;
            default: c = CmdFunction;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/clw_ifs.sv =====
interface clw_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] value;
    logic       row;
    logic [5:0] col;

    modport source (output valid, action, value, row, col, input ready);
    modport sink   (input valid, action, value, row, col, output ready);
endinterface

interface clw_phase_if;
    logic       valid;
    logic       ready;
    logic       rs_level;
    logic [3:0] data_nibble;
    logic       enable_level;
    logic [8:0] hold_ms;
    logic       last;

    modport source (output valid, rs_level, data_nibble, enable_level, hold_ms, last,
                    input ready);
    modport sink   (input valid, rs_level, data_nibble, enable_level, hold_ms, last,
                    output ready);
endinterface

interface clw_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/clw_front.sv =====
module clw_front
    import clw_pkg::*;
(
    clw_req_if.sink       req,
    input  clw_cfg_t      cfg,
    input  clw_q_status_t q_status,
    output logic          push,
    output clw_job_t      push_job
);

    logic       known;
    logic [7:0] cursor_addr;

    assign cursor_addr = (req.row ? LineOneBase : 8'h00) + {2'b00, req.col};

    always_comb
    begin
        known    = 1'b1;
        push_job = '0;
        case (action_t'(req.action))
            ActInit:
            begin
                push_job.is_init = 1'b1;
            end
            ActData:
            begin
                push_job.rs       = 1'b1;
                push_job.byte_val = req.value;
            end
            ActCmd:
            begin
                push_job.byte_val = req.value;
            end
            ActCursor:
            begin
                push_job.byte_val = CmdSetDdram | cursor_addr;
            end
            ActClear:
            begin
                push_job.byte_val = CmdClear;
                push_job.extra_ms = cfg.clear_wait_ms;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // unknown actions are taken and dropped
    assign req.ready = !q_status.full;
    assign push      = req.valid && !q_status.full && known;

endmodule

// ===== hw/rtl/clw_queue.sv =====
module clw_queue
    import clw_pkg::*;
#(
    parameter int unsigned DEPTH = QueueDepth
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  clw_job_t      push_job,
    input  logic          pop,
    output clw_job_t      head_job,
    output clw_q_status_t status
);

    localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
    localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

    clw_job_t        entry_reg [DEPTH];
    logic [IdxW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IdxW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign status.full  = (count_reg == Full);
    assign status.empty = (count_reg == '0);
    assign head_job     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastIdx) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastIdx) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/clw_back.sv =====
module clw_back
    import clw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  clw_cfg_t    cfg,
    input  logic        head_valid,
    input  clw_job_t    head_job,
    output logic        pop,
    clw_phase_if.source phase
);

    logic [StepW-1:0] step_reg, step_next;
    logic [3:0]       data_pins_reg, data_pins_next;
    logic             out_valid_reg;
    logic             rs_reg;
    logic [3:0]       nib_reg;
    logic             en_reg;
    logic [8:0]       hold_reg;
    logic             last_reg;

    logic             advance;
    logic             p_rs;
    logic [3:0]       p_nib;
    logic             p_en;
    logic [7:0]       p_base;
    logic [7:0]       p_extra;
    logic             p_last;
    logic             p_drives;
    logic [StepW-1:0] s_off;
    logic [StepW-1:0] t_off;
    logic [1:0]       wake_k;
    logic [7:0]       cmd_byte;

    assign s_off    = step_reg - 5'd1;
    assign t_off    = step_reg - InitCmdFirst;
    assign wake_k   = s_off[2:1];
    assign cmd_byte = init_cmd(t_off[4:2]);

    always_comb
    begin
        p_rs     = 1'b0;
        p_nib    = 4'h0;
        p_en     = 1'b0;
        p_base   = cfg.pulse_ms;
        p_extra  = 8'h00;
        p_last   = 1'b0;
        p_drives = 1'b1;
        if (head_job.is_init)
        begin
            p_last = (step_reg == InitLastStep);
            if (step_reg == InitWaitStep)
            begin
                p_nib    = data_pins_reg;
                p_base   = cfg.power_up_wait_ms;
                p_drives = 1'b0;
            end
            else if (step_reg <= InitNibLast)
            begin
                // wake-up nibbles 3,3,3 then 2; low phases of the first two wait longer
                p_nib = (wake_k == 2'd3) ? FourBitNib : WakeNibble;
                p_en  = ~s_off[0];
                if (s_off[0])
                begin
                    if (wake_k == 2'd0)
                    begin
                        p_extra = WakeExtraA;
                    end
                    else if (wake_k == 2'd1)
                    begin
                        p_extra = WakeExtraB;
                    end
                end
            end
            else
            begin
                p_nib = t_off[1] ? cmd_byte[3:0] : cmd_byte[7:4];
                p_en  = ~t_off[0];
            end
        end
        else
        begin
            p_rs    = head_job.rs;
            p_nib   = step_reg[1] ? head_job.byte_val[3:0] : head_job.byte_val[7:4];
            p_en    = ~step_reg[0];
            p_last  = (step_reg[1:0] == 2'd3);
            p_extra = p_last ? head_job.extra_ms : 8'h00;
        end
    end

    assign advance = head_valid && (!out_valid_reg || phase.ready);
    assign pop     = advance && p_last;

    always_comb
    begin
        step_next      = step_reg;
        data_pins_next = data_pins_reg;
        if (advance)
        begin
            step_next = p_last ? '0 : step_reg + 1'b1;
            if (p_drives)
            begin
                data_pins_next = p_nib;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            data_pins_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            data_pins_reg <= data_pins_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (phase.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rs_reg   <= p_rs;
            nib_reg  <= p_nib;
            en_reg   <= p_en;
            hold_reg <= {1'b0, p_base} + {1'b0, p_extra};
            last_reg <= p_last;
        end
    end

    assign phase.valid        = out_valid_reg;
    assign phase.rs_level     = rs_reg;
    assign phase.data_nibble  = nib_reg;
    assign phase.enable_level = en_reg;
    assign phase.hold_ms      = hold_reg;
    assign phase.last         = last_reg;

endmodule

// ===== hw/rtl/char_lcd_4bit_write_sequencer_unit.sv =====
// Character LCD write sequencer, 4-bit HD44780 style bus.
// req channel: one transaction per request (init, data, command, set cursor,
// clear). Unknown action codes are taken and produce nothing.
// phase channel: one transaction per pin phase (RS, D7..D4, E, hold in ms);
// last marks the final phase of a request.
// cfg channel: always ready; index 0 power-up wait, 1 pulse width,
// 2 clear wait. Indexes beyond these are ignored.
// A taken request goes into the queue before its first phase is registered.
// Throughput: one phase per cycle while the sink is ready and work is queued;
// a data, command, cursor or clear request is 4 phases and init is 29; the
// back-end step counter driving the single output register sets this.
// A request queue of QUEUE_DEPTH entries sits between the decoder and the
// sequencer, so new requests are taken while phases are still going out.
// When the sink stalls, the output register holds its phase and the queue
// fills; req.ready drops only once the queue is full.
// Reset: queue empties, no phase is valid, the D7..D4 shadow goes to 0 and
// the registers return to 50, 5 and 5 ms. No clearing pass is needed.
module char_lcd_4bit_write_sequencer_unit
    import clw_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    clw_req_if.sink     req,
    clw_phase_if.source phase,
    clw_cfg_if.sink     cfg
);

    clw_cfg_t      cfg_reg, cfg_next;
    clw_q_status_t q_status;
    clw_job_t      push_job;
    clw_job_t      head_job;
    logic          push;
    logic          pop;
    logic          head_valid;

    assign cfg.ready  = 1'b1;
    assign head_valid = !q_status.empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CfgPowerUpWait: cfg_next.power_up_wait_ms = cfg.data;
                CfgPulse:       cfg_next.pulse_ms         = cfg.data;
                CfgClearWait:   cfg_next.clear_wait_ms    = cfg.data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_up_wait_ms <= 8'd50;
            cfg_reg.pulse_ms         <= 8'd5;
            cfg_reg.clear_wait_ms    <= 8'd5;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    clw_front u_front (
        .req      (req),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    clw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    clw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .phase      (phase)
    );

    a_last_enable_low: assert property (@(posedge clk) disable iff (!rst_n)
        (phase.valid && phase.last) |-> !phase.enable_level)
        else $error("final phase left enable high");

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty");

    a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase.valid && phase.ready && !head_valid) |=> !phase.valid)
        else $error("phase output valid with no pending work");

    a_pop_only_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

endmodule

// ===== tb/tb_char_lcd_4bit_write_sequencer_unit.sv =====
`timescale 1ns / 1ps

module tb_char_lcd_4bit_write_sequencer_unit;
    import clw_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int SettleCycles  = 8;
    localparam int ItemsPerSeg   = 80;
    localparam int NumSegs       = 6;

    // action codes outside the defined set, taken and ignored
    localparam logic [2:0] ActBadFirst = 3'd5;
    localparam logic [2:0] ActBadMid   = 3'd6;
    localparam logic [2:0] ActBadLast  = 3'd7;
    // register index with no register behind it
    localparam logic [1:0] CfgSpare    = 2'd3;

    localparam logic [7:0] DdramBase   = 8'h80;
    localparam logic [7:0] Line2Offset = 8'h40;
    localparam logic [7:0] ClearDisp   = 8'h01;
    localparam logic [3:0] WakeNib     = 4'h3;
    localparam logic [3:0] Bus4Nib     = 4'h2;
    localparam logic [7:0] WakeHoldA   = 8'd5;
    localparam logic [7:0] WakeHoldB   = 8'd1;
    localparam logic [0:4][7:0] InitCmds = {8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};

    typedef struct packed {
        logic [2:0] act;
        logic [7:0] value;
        logic       row;
        logic [5:0] col;
    } lcd_req_t;

    typedef struct packed {
        logic       rs;
        logic [3:0] nib;
        logic       en;
        logic [8:0] hold;
        logic       last;
    } phase_t;

    typedef struct {
        lcd_req_t rq;
        int       n_typed;   // -1: use predictor
        phase_t   typed [4];
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    clw_req_if   req_ch ();
    clw_phase_if ph_ch ();
    clw_cfg_if   cfg_ch ();

    char_lcd_4bit_write_sequencer_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .phase (ph_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    // predictor state and register mirror
    logic [7:0] pwr_wait    = 8'd50;
    logic [7:0] pulse_w     = 8'd5;
    logic [7:0] clr_wait    = 8'd5;
    logic [3:0] shadow_pins = 4'd0;

    phase_t   req_phases [$];
    phase_t   lcd_expected [$];
    phase_t   want_ph;
    dir_row_t dir_tab [$];

    int errors       = 0;
    int stall_cycles = 0;
    int src_idle_pct = 36;
    int snk_idle_pct = 49;

    function automatic phase_t ph(input logic rs, input logic [3:0] nib, input logic en,
                                  input logic [8:0] hold, input logic last);
        phase_t p;
        p.rs   = rs;
        p.nib  = nib;
        p.en   = en;
        p.hold = hold;
        p.last = last;
        return p;
    endfunction

    function automatic void dir_add(input logic [2:0] act, input logic [7:0] value,
                                    input logic row, input logic [5:0] col,
                                    input int n = -1,
                                    input phase_t p0 = '0, input phase_t p1 = '0,
                                    input phase_t p2 = '0, input phase_t p3 = '0);
        dir_row_t r;
        r.rq.act   = act;
        r.rq.value = value;
        r.rq.row   = row;
        r.rq.col   = col;
        r.n_typed  = n;
        r.typed[0] = p0;
        r.typed[1] = p1;
        r.typed[2] = p2;
        r.typed[3] = p3;
        dir_tab.push_back(r);
    endfunction

    function automatic void emit(input logic rs, input logic [3:0] nib, input logic en,
                                 input logic [8:0] hold);
        req_phases.push_back(ph(rs, nib, en, hold, 1'b0));
    endfunction

    function automatic void emit_nibble(input logic rs, input logic [3:0] nib,
                                        input logic [7:0] extra);
        shadow_pins = nib;
        emit(rs, nib, 1'b1, {1'b0, pulse_w});
        emit(rs, nib, 1'b0, {1'b0, pulse_w} + {1'b0, extra});
    endfunction

    function automatic void emit_byte(input logic rs, input logic [7:0] b,
                                      input logic [7:0] extra);
        emit_nibble(rs, b[7:4], 8'd0);
        emit_nibble(rs, b[3:0], extra);
    endfunction

    // fills req_phases with the pin phases one request produces
    function automatic void predict_request(input lcd_req_t rq);
        logic [7:0] addr;
        req_phases.delete();
        case (rq.act)
            ActInit:
            begin
                emit(1'b0, shadow_pins, 1'b0, {1'b0, pwr_wait});
                emit_nibble(1'b0, WakeNib, WakeHoldA);
                emit_nibble(1'b0, WakeNib, WakeHoldB);
                emit_nibble(1'b0, WakeNib, 8'd0);
                emit_nibble(1'b0, Bus4Nib, 8'd0);
                for (int k = 0; k < 5; k++)
                    emit_byte(1'b0, InitCmds[k], 8'd0);
            end
            ActData:   emit_byte(1'b1, rq.value, 8'd0);
            ActCmd:    emit_byte(1'b0, rq.value, 8'd0);
            ActCursor:
            begin
                addr = (rq.row ? Line2Offset : 8'd0) + {2'b00, rq.col};
                emit_byte(1'b0, DdramBase | addr, 8'd0);
            end
            ActClear:  emit_byte(1'b0, ClearDisp, clr_wait);
            default:   ;
        endcase
        if (req_phases.size() > 0)
            req_phases[req_phases.size() - 1].last = 1'b1;
    endfunction

    task automatic send_request(input lcd_req_t rq);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= rq.act;
        req_ch.value  <= rq.value;
        req_ch.row    <= rq.row;
        req_ch.col    <= rq.col;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // leaves cfg valid high; caller lowers it after the last write
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            CfgPowerUpWait: pwr_wait = d;
            CfgPulse:       pulse_w  = d;
            CfgClearWait:   clr_wait = d;
            default:        ;
        endcase
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (lcd_expected.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic compare_pin(input string what, input int unsigned e, input int unsigned a);
        if (e != a)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, e, a);
            errors++;
        end
    endtask

    always @(posedge clk)
        ph_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && ph_ch.valid && ph_ch.ready)
        begin
            if (lcd_expected.size() == 0)
            begin
                $display("%0t: phase with nothing pending, expected none, actual rs %0d d %h e %0d hold %0d last %0d",
                         $time, ph_ch.rs_level, ph_ch.data_nibble, ph_ch.enable_level,
                         ph_ch.hold_ms, ph_ch.last);
                errors++;
            end
            else
            begin
                want_ph = lcd_expected.pop_front();
                compare_pin("rs_level", want_ph.rs, ph_ch.rs_level);
                compare_pin("data_nibble", want_ph.nib, ph_ch.data_nibble);
                compare_pin("enable_level", want_ph.en, ph_ch.enable_level);
                compare_pin("hold_ms", want_ph.hold, ph_ch.hold_ms);
                compare_pin("last", want_ph.last, ph_ch.last);
            end
        end
    end

    // watchdog: cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (ph_ch.valid && ph_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WatchdogLimit)
        begin
            $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
            $display("*** FAILED ***");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        dir_row_t r;
        lcd_req_t rq;
        int       known;
        int       pick;

        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.action = ActInit;
        req_ch.value  = 8'd0;
        req_ch.row    = 1'b0;
        req_ch.col    = 6'd0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CfgPowerUpWait;
        cfg_ch.data   = 8'd0;
        ph_ch.ready   = 1'b0;

        // rows with typed expectations assume reset register values
        dir_add(ActData, 8'hFF, 1'b0, 6'd0, 4,
                ph(1'b1, 4'hF, 1'b1, 9'd5, 1'b0), ph(1'b1, 4'hF, 1'b0, 9'd5, 1'b0),
                ph(1'b1, 4'hF, 1'b1, 9'd5, 1'b0), ph(1'b1, 4'hF, 1'b0, 9'd5, 1'b1));
        dir_add(ActCmd, 8'h00, 1'b0, 6'd0, 4,
                ph(1'b0, 4'h0, 1'b1, 9'd5, 1'b0), ph(1'b0, 4'h0, 1'b0, 9'd5, 1'b0),
                ph(1'b0, 4'h0, 1'b1, 9'd5, 1'b0), ph(1'b0, 4'h0, 1'b0, 9'd5, 1'b1));
        dir_add(ActClear, 8'h00, 1'b0, 6'd0, 4,
                ph(1'b0, 4'h0, 1'b1, 9'd5, 1'b0), ph(1'b0, 4'h0, 1'b0, 9'd5, 1'b0),
                ph(1'b0, 4'h1, 1'b1, 9'd5, 1'b0), ph(1'b0, 4'h1, 1'b0, 9'd10, 1'b1));
        dir_add(ActCursor, 8'h00, 1'b1, 6'd63, 4,
                ph(1'b0, 4'hF, 1'b1, 9'd5, 1'b0), ph(1'b0, 4'hF, 1'b0, 9'd5, 1'b0),
                ph(1'b0, 4'hF, 1'b1, 9'd5, 1'b0), ph(1'b0, 4'hF, 1'b0, 9'd5, 1'b1));
        dir_add(ActBadLast, 8'hFF, 1'b1, 6'd63, 0);
        dir_add(ActBadFirst, 8'h12, 1'b0, 6'd5);
        dir_add(ActBadMid, 8'h34, 1'b1, 6'd9);
        // init right after pins were left at all ones
        dir_add(ActInit, 8'h00, 1'b0, 6'd0);
        dir_add(ActData, 8'h00, 1'b0, 6'd0);
        dir_add(ActCmd, 8'hFF, 1'b1, 6'd63);
        dir_add(ActCursor, 8'h00, 1'b0, 6'd0);
        dir_add(ActCursor, 8'h00, 1'b1, 6'd0);
        dir_add(ActCursor, 8'h00, 1'b0, 6'd39);
        dir_add(ActCursor, 8'hFF, 1'b0, 6'd63);
        dir_add(ActData, 8'hA5, 1'b0, 6'd0);
        dir_add(ActCmd, 8'h5A, 1'b0, 6'd0);
        dir_add(ActData, 8'h55, 1'b1, 6'd63);
        dir_add(ActInit, 8'hFF, 1'b1, 6'd63);
        dir_add(ActClear, 8'hAA, 1'b1, 6'd42);
        dir_add(ActData, 8'h80, 1'b0, 6'd1);
        dir_add(ActInit, 8'h00, 1'b0, 6'd0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            r = dir_tab[i];
            send_request(r.rq);
            predict_request(r.rq);
            if (r.n_typed < 0)
                lcd_expected = {lcd_expected, req_phases};
            else
                for (int k = 0; k < r.n_typed; k++)
                    lcd_expected.push_back(r.typed[k]);
        end

        for (int seg = 0; seg < NumSegs; seg++)
        begin
            drain();
            case (seg)
                0:
                begin
                    write_reg(CfgPowerUpWait, 8'd0);
                    write_reg(CfgPulse, 8'd1);
                    write_reg(CfgClearWait, 8'd0);
                end
                1:
                begin
                    write_reg(CfgPowerUpWait, 8'd255);
                    write_reg(CfgPulse, 8'd255);
                    write_reg(CfgClearWait, 8'd255);
                end
                2:
                begin
                    // zero pulse width is passed through as is
                    write_reg(CfgPulse, 8'd0);
                    write_reg(CfgPowerUpWait, 8'($urandom));
                    write_reg(CfgClearWait, 8'($urandom));
                end
                3:
                begin
                    write_reg(CfgSpare, 8'($urandom));
                    write_reg(CfgPulse, 8'($urandom_range(1, 255)));
                    write_reg(CfgClearWait, 8'($urandom));
                end
                default:
                begin
                    write_reg(CfgPowerUpWait, 8'($urandom));
                    write_reg(CfgPulse, 8'($urandom_range(1, 255)));
                    write_reg(CfgClearWait, 8'($urandom));
                    write_reg(CfgSpare, 8'($urandom));
                end
            endcase
            cfg_ch.valid <= 1'b0;

            case (seg / 2)
                0:
                begin
                    src_idle_pct = 36;
                    snk_idle_pct = 49;
                end
                1:
                begin
                    src_idle_pct = 49;
                    snk_idle_pct = 36;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase

            known = 0;
            while (known < ItemsPerSeg)
            begin
                pick     = $urandom_range(0, 99);
                rq.value = 8'($urandom);
                rq.row   = 1'($urandom);
                rq.col   = 6'($urandom);
                if (pick < 8)
                    rq.act = 3'($urandom_range(ActBadFirst, ActBadLast));
                else if (pick < 18)
                    rq.act = ActInit;
                else
                    rq.act = 3'($urandom_range(ActData, ActClear));
                if (rq.act <= ActClear)
                    known++;
                send_request(rq);
                predict_request(rq);
                lcd_expected = {lcd_expected, req_phases};
            end
        end

        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/clw_pkg.sv
hw/rtl/clw_ifs.sv
hw/rtl/clw_front.sv
hw/rtl/clw_queue.sv
hw/rtl/clw_back.sv
hw/rtl/char_lcd_4bit_write_sequencer_unit.sv
tb/tb_char_lcd_4bit_write_sequencer_unit.sv
